/* sv/twht_pkg.sv */
// shared types and constants for the touch window hit tracker
// no dependencies; imported by twht_hit_test, touch_window_hit_tracker_unit and the bench
`default_nettype none

package twht_pkg;

    localparam int COORD_BITS   = 11;
    localparam int REFR_BITS    = 16;
    localparam int CFG_BITS     = 2 + 4 * COORD_BITS + REFR_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int MASK_BITS    = 8;

    // packed window setup, bit 0 is the active flag
    typedef struct packed {
        logic [REFR_BITS-1:0]  refractory;
        logic [COORD_BITS-1:0] half_y;
        logic [COORD_BITS-1:0] half_x;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cx;
        logic                  ellipse;
        logic                  active;
    } t_win_cfg;

    localparam t_win_cfg WIN_RESET = '{
        refractory: '0,
        half_y:     COORD_BITS'(100),
        half_x:     COORD_BITS'(100),
        cy:         COORD_BITS'(320),
        cx:         COORD_BITS'(400),
        ellipse:    1'b1,
        active:     1'b0
    };

    typedef enum logic [1:0] {
        ST_UNDEF = 2'd0,
        ST_IN    = 2'd1,
        ST_OUT   = 2'd2
    } t_win_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] touch_x;
        logic [COORD_BITS-1:0] touch_y;
    } t_touch_in;

    typedef struct packed {
        logic [MASK_BITS-1:0]  changed_mask;
        logic [MASK_BITS-1:0]  inside_mask;
        logic [COORD_BITS-1:0] report_y;
        logic [COORD_BITS-1:0] report_x;
    } t_touch_rpt;

    // request to the hit test unit
    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        t_win_cfg              cfg;
    } t_hit_req;

    // status back from the hit test unit
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_hit_rsp;

endpackage

`default_nettype wire

/* sv/twht_hit_test.sv */
// point-in-window test for one window at a time, with one shared multiplier
// depends on twht_pkg
`default_nettype none

module twht_hit_test
    import twht_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_hit_req i_req,
    output t_hit_rsp      o_rsp
);

    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int SQ_BITS   = 2 * PROD_BITS;

    typedef enum logic [3:0] {
        H_IDLE, H_CHECK, H_AP, H_BP, H_CP, H_A2, H_B2, H_C2, H_CMP
    } t_hstate;

    t_hstate                r_state;
    logic                   r_done;
    logic                   r_inside;
    logic                   r_ellipse;
    logic [COORD_BITS-1:0]  r_adx;
    logic [COORD_BITS-1:0]  r_ady;
    logic [COORD_BITS-1:0]  r_px;
    logic [COORD_BITS-1:0]  r_py;
    logic [PROD_BITS-1:0]   r_a;
    logic [PROD_BITS-1:0]   r_b;
    logic [PROD_BITS-1:0]   r_c;
    logic [SQ_BITS-1:0]     r_p;
    logic [SQ_BITS:0]       r_sum;

    logic [COORD_BITS:0]    dx;
    logic [COORD_BITS:0]    dy;
    logic [COORD_BITS:0]    n_adx;
    logic [COORD_BITS:0]    n_ady;
    logic [PROD_BITS-1:0]   mul_a;
    logic [PROD_BITS-1:0]   mul_b;
    logic [SQ_BITS-1:0]     mul_p;

    // absolute offsets from the window center
    always_comb begin
        dx    = {1'b0, i_req.x} - {1'b0, i_req.cfg.cx};
        dy    = {1'b0, i_req.y} - {1'b0, i_req.cfg.cy};
        n_adx = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        n_ady = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            H_AP: begin
                mul_a = PROD_BITS'(r_adx);
                mul_b = PROD_BITS'(r_py);
            end
            H_BP: begin
                mul_a = PROD_BITS'(r_ady);
                mul_b = PROD_BITS'(r_px);
            end
            H_CP: begin
                mul_a = PROD_BITS'(r_px);
                mul_b = PROD_BITS'(r_py);
            end
            H_A2: begin
                mul_a = r_a;
                mul_b = r_a;
            end
            H_B2: begin
                mul_a = r_b;
                mul_b = r_b;
            end
            H_C2: begin
                mul_a = r_c;
                mul_b = r_c;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= H_IDLE;
            r_done   <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            // answer is ready after the rectangle check or the final compare
            r_done <= (r_state == H_CMP) ||
                      ((r_state == H_CHECK) &&
                       (!r_ellipse || r_px == '0 || r_py == '0));
            unique case (r_state)
                H_IDLE: begin
                    if (i_req.start) begin
                        r_adx     <= n_adx[COORD_BITS-1:0];
                        r_ady     <= n_ady[COORD_BITS-1:0];
                        r_px      <= i_req.cfg.half_x;
                        r_py      <= i_req.cfg.half_y;
                        r_ellipse <= i_req.cfg.ellipse;
                        r_state   <= H_CHECK;
                    end
                end
                H_CHECK: begin
                    if (!r_ellipse) begin
                        r_inside <= (r_adx < r_px) && (r_ady < r_py);
                        r_state  <= H_IDLE;
                    end else if (r_px == '0 || r_py == '0) begin
                        r_inside <= 1'b0;
                        r_state  <= H_IDLE;
                    end else begin
                        r_state <= H_AP;
                    end
                end
                H_AP: begin
                    r_p     <= mul_p;
                    r_state <= H_BP;
                end
                H_BP: begin
                    r_a     <= r_p[PROD_BITS-1:0];
                    r_p     <= mul_p;
                    r_state <= H_CP;
                end
                H_CP: begin
                    r_b     <= r_p[PROD_BITS-1:0];
                    r_p     <= mul_p;
                    r_state <= H_A2;
                end
                H_A2: begin
                    r_c     <= r_p[PROD_BITS-1:0];
                    r_p     <= mul_p;
                    r_state <= H_B2;
                end
                H_B2: begin
                    r_sum   <= {1'b0, r_p};
                    r_p     <= mul_p;
                    r_state <= H_C2;
                end
                H_C2: begin
                    r_sum   <= r_sum + {1'b0, r_p};
                    r_p     <= mul_p;
                    r_state <= H_CMP;
                end
                H_CMP: begin
                    r_inside <= r_sum < {1'b0, r_p};
                    r_state  <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy = (r_state != H_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_inside;

endmodule

`default_nettype wire

/* sv/touch_window_hit_tracker_unit.sv */
// touch window hit tracker, top level: window setup, per-window status, sequencer
// depends on twht_pkg and twht_hit_test
`default_nettype none

// usage
// - input channel (i_in_valid / o_in_ready) carries one touch word (x, y)
// - output channel (o_out_valid / i_out_ready) carries one report word when
//   some window changed: changed mask, inside mask, y, x; no word otherwise
// - config port: i_cfg_we with i_cfg_index picks window setup register,
//   writes take effect at once and are meant for idle periods only;
//   toggling the active bit puts that window back to undefined
// - windows are visited in order by one sequencer and one hit test unit with
//   a shared multiplier; an inactive window needs no hit test, an active
//   rectangle (or degenerate ellipse) ends at the rectangle check, and an
//   active ellipse window runs the multiplier steps and a final compare
// - per item: accept, visit every window, load the report register if due
// - o_in_ready is high only while the sequencer is idle; one word at a time
// - the report register decouples the sides: a new touch word is taken while
//   the last report still waits; a report that finds the register full
//   holds the sequencer until the receiver takes the old one
// - reset (synchronous, active low) loads the default setup into every
//   window, sets every status to undefined and clears all countdowns
module touch_window_hit_tracker_unit
    import twht_pkg::*;
#(
    parameter int WINDOWS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_touch_in               i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output t_touch_rpt                   o_out_data,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOWS - 1);

    typedef enum logic [1:0] {T_IDLE, T_WIN, T_WAIT, T_PUSH} t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_idx;
    logic [COORD_BITS-1:0]  r_x;
    logic [COORD_BITS-1:0]  r_y;
    logic [MASK_BITS-1:0]   r_changed;
    logic [MASK_BITS-1:0]   r_inside;
    logic                   r_report;
    t_win_cfg               r_setup  [WINDOWS];
    t_win_state             r_status [WINDOWS];
    logic [REFR_BITS-1:0]   r_cd     [WINDOWS];
    logic                   r_out_valid;
    t_touch_rpt             r_out;

    t_win_cfg               cur_cfg;
    t_win_state             cur_st;
    logic [REFR_BITS-1:0]   cur_cd;
    t_win_state             n_status;
    logic [REFR_BITS-1:0]   n_cd;
    logic                   n_chg;
    logic                   n_in;
    logic                   step_done;
    logic                   step_rep;
    logic                   cfg_hit;
    logic [IDX_W-1:0]       cfg_slot;
    logic                   out_free;
    t_hit_req               hit_req;
    t_hit_rsp               hit_rsp;

    assign cur_cfg = r_setup[r_idx];
    assign cur_st  = r_status[r_idx];
    assign cur_cd  = r_cd[r_idx];

    // status update of the current window once its hit test is back
    always_comb begin
        n_status = cur_st;
        n_cd     = cur_cd;
        n_chg    = 1'b0;
        n_in     = 1'b0;
        if (hit_rsp.hit) begin
            n_in = 1'b1;
            if (cur_st != ST_IN) begin
                n_status = ST_IN;
                n_cd     = '0;
                n_chg    = 1'b1;
            end
        end else if (cur_st != ST_OUT) begin
            // refractory countdown: load, count down, leave at one; leave at once with no refractory
            if (cur_cfg.refractory != '0 && cur_cd == '0) begin
                n_cd = cur_cfg.refractory;
            end else if (cur_cfg.refractory != '0 && cur_cd != REFR_BITS'(1)) begin
                n_cd = cur_cd - 1'b1;
            end else begin
                n_cd     = '0;
                n_status = ST_OUT;
                n_chg    = 1'b1;
            end
        end
    end

    // one window finished this cycle, and whether it asks for a report
    always_comb begin
        step_done = 1'b0;
        step_rep  = 1'b0;
        if (r_state == T_WIN && !cur_cfg.active) begin
            step_done = 1'b1;
            step_rep  = (cur_st == ST_UNDEF);
        end else if (r_state == T_WAIT && hit_rsp.done) begin
            step_done = 1'b1;
            step_rep  = n_chg;
        end
    end

    assign hit_req.start = (r_state == T_WIN) && cur_cfg.active;
    assign hit_req.x     = r_x;
    assign hit_req.y     = r_y;
    assign hit_req.cfg   = cur_cfg;

    twht_hit_test u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hit_req),
        .o_rsp   (hit_rsp)
    );

    assign cfg_hit  = i_cfg_we && (int'(i_cfg_index) < WINDOWS);
    assign cfg_slot = i_cfg_index[IDX_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_idx       <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOWS; i++) begin
                r_setup[i]  <= WIN_RESET;
                r_status[i] <= ST_UNDEF;
                r_cd[i]     <= '0;
            end
        end else begin
            // receiver took the word and no new one is loaded behind it
            if (r_state != T_PUSH && r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_x       <= i_in_data.touch_x;
                        r_y       <= i_in_data.touch_y;
                        r_changed <= '0;
                        r_inside  <= '0;
                        r_report  <= 1'b0;
                        r_idx     <= '0;
                        r_state   <= T_WIN;
                    end
                end
                T_WIN: begin
                    if (!cur_cfg.active) begin
                        // inactive and undefined settles to out without a change bit
                        if (cur_st == ST_UNDEF) begin
                            r_status[r_idx] <= ST_OUT;
                        end
                    end else begin
                        r_state <= T_WAIT;
                    end
                end
                T_WAIT: begin
                    if (hit_rsp.done) begin
                        r_status[r_idx]  <= n_status;
                        r_cd[r_idx]      <= n_cd;
                        r_changed[r_idx] <= n_chg;
                        r_inside[r_idx]  <= n_in;
                    end
                end
                T_PUSH: begin
                    if (out_free) begin
                        r_out.changed_mask <= r_changed;
                        r_out.inside_mask  <= r_inside;
                        r_out.report_y     <= r_y;
                        r_out.report_x     <= r_x;
                        r_out_valid        <= 1'b1;
                        r_state            <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase

            // advance to the next window or finish the word
            if (step_done) begin
                r_report <= r_report | step_rep;
                if (r_idx == LAST_IDX) begin
                    r_state <= (r_report || step_rep) ? T_PUSH : T_IDLE;
                end else begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= T_WIN;
                end
            end

            // setup writes, meant only while idle; the block itself does not enforce it
            if (cfg_hit) begin
                if (i_cfg_data[0] != r_setup[cfg_slot].active) begin
                    r_status[cfg_slot] <= ST_UNDEF;
                    r_cd[cfg_slot]     <= '0;
                end
                r_setup[cfg_slot] <= t_win_cfg'(i_cfg_data);
            end
        end
    end

    assign o_in_ready  = (r_state == T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // hit test answers only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_rsp.done |-> (r_state == T_WAIT))
        else $error("hit test done outside of wait state");

    // hit test unit is free whenever a new touch word can come in
    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_IDLE) |-> !hit_rsp.busy)
        else $error("hit test busy while sequencer idle");

    // a window that is out never keeps a pending countdown
    a_out_no_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status[r_idx] == ST_OUT) |-> (r_cd[r_idx] == '0))
        else $error("countdown pending on a window that is out");

    // a report is loaded only from the push state with a report pending
    a_rpt_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == T_PUSH) && $past(r_report))
        else $error("report loaded without a pending report");

endmodule

`default_nettype wire

/* bench/tb_touch_window_hit_tracker_unit.sv */
// self-checking bench for touch_window_hit_tracker_unit: directed touch table, then random phases
// relies on twht_pkg and the unit under test; tracks window status in its own shadow model
`timescale 1ns / 1ps

module tb_touch_window_hit_tracker_unit
    import twht_pkg::*;
();

    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 195;
    localparam int SETTLE       = 100;       // the worst item has eight active ellipse windows
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DIRECTED_ROWS = 25;

    // one row of the directed table; pinned rows carry their report typed in
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  setup_first;
        logic                  pinned;
        logic                  fires;
        logic [MASK_BITS-1:0]  chg;
        logic [MASK_BITS-1:0]  ins;
    } t_touch_row;

    localparam t_touch_row DIRECTED [DIRECTED_ROWS] = '{
        // after reset every inactive window retires from undefined: report, no bits
        '{11'd400,  11'd320,  1'b0, 1'b1, 1'b1, 8'h00, 8'h00},
        // nothing left to retire, so no word at all
        '{11'd400,  11'd320,  1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
        // directed windows loaded before this row, all active ones back to undefined
        '{11'd100,  11'd100,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
        // rectangle edges: inside at half-1, outside at half
        '{11'd109,  11'd100,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd110,  11'd100,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd100,  11'd91,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd100,  11'd90,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        // ellipse center and its axis ends
        '{11'd1000, 11'd1000, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1049, 11'd1000, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1050, 11'd1000, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1000, 11'd1029, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1000, 11'd1030, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        // repeated outside samples run the refractory countdowns out
        '{11'd5,    11'd5,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd5,    11'd5,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd5,    11'd5,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        // zero half sizes never count as inside, even at the center
        '{11'd500,  11'd500,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd300,  11'd0,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        // one-pixel ellipse: only the exact center hits
        '{11'd1024, 11'd1024, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1025, 11'd1024, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        // coordinate corners
        '{11'd0,    11'd0,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd2047, 11'd2047, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd2047, 11'd0,    1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd0,    11'd2047, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd2046, 11'd2046, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
        '{11'd1024, 11'd1024, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}
    };

    // clock and block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_touch_in               i_in_data;
    logic                    o_out_valid;
    logic                    i_out_ready;
    t_touch_rpt              o_out_data;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]     i_cfg_data;

    // shadow window state
    t_win_cfg       win_setup  [8];
    t_win_state     win_state  [8];
    logic [REFR_BITS-1:0] exit_count [8];

    // reports still owed by the block, oldest first
    t_touch_rpt     pending_reports [$];

    // typed-in report for the word now on the input channel
    bit             pin_on;
    bit             pin_fires;
    t_touch_rpt     pin_word;

    int             send_idle_pct;
    int             recv_stall_pct;
    int             mismatches;
    int             words_taken;
    int             reports_checked;
    int             setup_writes;
    int unsigned    cycle_count;

    touch_window_hit_tracker_unit #(.WINDOWS(8)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls at the rate of the current phase
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_win_cfg make_window(bit act, bit ell, int cx, int cy,
                                             int hx, int hy, int refr);
        t_win_cfg w;
        w.active     = act;
        w.ellipse    = ell;
        w.cx         = COORD_BITS'(cx);
        w.cy         = COORD_BITS'(cy);
        w.half_x     = COORD_BITS'(hx);
        w.half_y     = COORD_BITS'(hy);
        w.refractory = REFR_BITS'(refr);
        return w;
    endfunction

    // half sizes: mostly modest, sometimes zero, full scale or anything
    function automatic int random_half();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 0;
        else if (pick == 1)
            return 2047;
        else if (pick < 4)
            return $urandom_range(2047);
        return $urandom_range(300, 1);
    endfunction

    function automatic t_win_cfg random_window();
        int pick;
        int refr;
        pick = $urandom_range(9);
        // short refractory counts so countdowns actually run out
        if (pick < 7)
            refr = $urandom_range(4);
        else if (pick < 9)
            refr = $urandom_range(40);
        else
            refr = $urandom_range(65535);
        return make_window($urandom_range(99) < 80, 1'($urandom_range(1)),
                           $urandom_range(2047), $urandom_range(2047),
                           random_half(), random_half(), refr);
    endfunction

    // exact hit test, wide enough for 2047^4 terms
    function automatic bit covers_point(t_win_cfg w, logic [COORD_BITS-1:0] x,
                                        logic [COORD_BITS-1:0] y);
        longint dx;
        longint dy;
        longint px;
        longint py;
        dx = longint'(x) - longint'(w.cx);
        dy = longint'(y) - longint'(w.cy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        px = longint'(w.half_x);
        py = longint'(w.half_y);
        if (w.ellipse) begin
            if (px == 0 || py == 0)
                return 1'b0;
            return dx * dx * py * py + dy * dy * px * px < px * px * py * py;
        end
        return dx < px && dy < py;
    endfunction

    // walk all windows for one touch word; returns 1 when a report is due
    function automatic bit track_touch(input t_touch_in t, output t_touch_rpt rpt);
        logic [MASK_BITS-1:0] changes;
        logic [MASK_BITS-1:0] insides;
        bit                   fires;
        changes = '0;
        insides = '0;
        fires   = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!win_setup[i].active) begin
                // inactive undefined window retires quietly, but still reports
                if (win_state[i] == ST_UNDEF) begin
                    win_state[i] = ST_OUT;
                    fires = 1'b1;
                end
            end else if (covers_point(win_setup[i], t.touch_x, t.touch_y)) begin
                if (win_state[i] != ST_IN) begin
                    win_state[i]  = ST_IN;
                    exit_count[i] = '0;
                    changes[i]    = 1'b1;
                    fires         = 1'b1;
                end
                insides[i] = 1'b1;
            end else if (win_state[i] != ST_OUT) begin
                // leaving: load, count down, and only the sample at 1 lets go (any sample with no refractory)
                if (win_setup[i].refractory != 0 && exit_count[i] == 0) begin
                    exit_count[i] = win_setup[i].refractory;
                end else if (win_setup[i].refractory != 0 && exit_count[i] != 1) begin
                    exit_count[i] = exit_count[i] - 1'b1;
                end else begin
                    exit_count[i] = '0;
                    win_state[i]  = ST_OUT;
                    changes[i]    = 1'b1;
                    fires         = 1'b1;
                end
            end
        end
        rpt = '{changed_mask: changes, inside_mask: insides,
                report_y: t.touch_y, report_x: t.touch_x};
        return fires;
    endfunction

    // scoreboard: outgoing words first, then predict the incoming one
    always @(posedge i_clk) begin
        bit         fires;
        t_touch_rpt rpt;
        t_touch_rpt want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                reports_checked++;
                if (pending_reports.size() == 0) begin
                    $error("report word with none pending: %h", o_out_data);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_out_data.changed_mask !== want.changed_mask) begin
                        $error("changed_mask: expected %h, got %h",
                               want.changed_mask, o_out_data.changed_mask);
                        mismatches++;
                    end
                    if (o_out_data.inside_mask !== want.inside_mask) begin
                        $error("inside_mask: expected %h, got %h",
                               want.inside_mask, o_out_data.inside_mask);
                        mismatches++;
                    end
                    if (o_out_data.report_y !== want.report_y) begin
                        $error("report_y: expected %0d, got %0d",
                               want.report_y, o_out_data.report_y);
                        mismatches++;
                    end
                    if (o_out_data.report_x !== want.report_x) begin
                        $error("report_x: expected %0d, got %0d",
                               want.report_x, o_out_data.report_x);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                words_taken++;
                fires = track_touch(i_in_data, rpt);
                // typed-in rows override the shadow model's answer
                if (pin_on) begin
                    fires = pin_fires;
                    rpt   = pin_word;
                end
                if (fires)
                    pending_reports.push_back(rpt);
            end
        end
    end

    // one touch word: optional idle gap, then hold valid until taken
    task automatic send_touch(input t_touch_in t, input bit pinned, input bit fires,
                              input t_touch_rpt rpt);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        pin_on     = pinned;
        pin_fires  = fires;
        pin_word   = rpt;
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending, wait for every owed report, then let the sequencer settle
    task automatic quiesce(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // back-to-back setup writes; shadow copy follows each one
    task automatic load_windows(input t_win_cfg set [8], input bit [7:0] which);
        for (int i = 0; i < 8; i++) begin
            if (which[i]) begin
                @(negedge i_clk);
                i_cfg_we    <= 1'b1;
                i_cfg_index <= CFG_IDX_BITS'(i);
                i_cfg_data  <= set[i];
                // flipping the active bit sends the window back to undefined
                if (set[i].active != win_setup[i].active) begin
                    win_state[i]  = ST_UNDEF;
                    exit_count[i] = '0;
                end
                win_setup[i] = set[i];
                setup_writes++;
            end
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_win_cfg   set [8];
        t_touch_in  t;
        t_touch_rpt rpt;
        t_win_cfg   w;
        int         sel;
        int         spanx;
        int         spany;
        int         target;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pin_on         = 1'b0;
        pin_fires      = 1'b0;
        pin_word       = '0;
        mismatches     = 0;
        words_taken    = 0;
        reports_checked = 0;
        setup_writes   = 0;
        cycle_count    = 0;
        target         = 0;
        for (int i = 0; i < 8; i++) begin
            win_setup[i]  = WIN_RESET;
            win_state[i]  = ST_UNDEF;
            exit_count[i] = '0;
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed windows: plain and degenerate shapes, both register extremes
        set[0] = make_window(1, 0, 100, 100, 10, 10, 0);
        set[1] = make_window(1, 1, 1000, 1000, 50, 30, 2);
        set[2] = make_window(1, 1, 500, 500, 0, 20, 0);
        set[3] = make_window(1, 0, 0, 0, 2047, 2047, 0);
        set[4] = '1;
        set[5] = '0;
        set[6] = make_window(1, 0, 300, 0, 0, 5, 3);
        set[7] = make_window(1, 1, 1024, 1024, 1, 1, 1);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].setup_first) begin
                quiesce(SETTLE);
                load_windows(set, 8'hFF);
            end
            t   = '{touch_x: DIRECTED[k].x, touch_y: DIRECTED[k].y};
            rpt = '{changed_mask: DIRECTED[k].chg, inside_mask: DIRECTED[k].ins,
                    report_y: DIRECTED[k].y, report_x: DIRECTED[k].x};
            send_touch(t, DIRECTED[k].pinned, DIRECTED[k].fires, rpt);
        end

        // random phases: fresh setups for all or a random subset of windows, one of four idle mixes
        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce(SETTLE);
            for (int i = 0; i < 8; i++)
                set[i] = random_window();
            load_windows(set, phase == 0 ? 8'hFF : 8'($urandom));
            unique case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // linger around one window so entries and exits come in runs
                if ($urandom_range(5) == 0)
                    target = $urandom_range(7);
                w   = win_setup[target];
                sel = $urandom_range(99);
                if (sel < 60) begin
                    spanx = int'(w.half_x) + int'(w.half_x) / 4 + 2;
                    spany = int'(w.half_y) + int'(w.half_y) / 4 + 2;
                    t.touch_x = COORD_BITS'(int'(w.cx) + int'($urandom_range(2 * spanx)) - spanx);
                    t.touch_y = COORD_BITS'(int'(w.cy) + int'($urandom_range(2 * spany)) - spany);
                end else if (sel < 80) begin
                    t.touch_x = COORD_BITS'($urandom);
                    t.touch_y = COORD_BITS'($urandom);
                end else if (sel < 90) begin
                    t.touch_x = $urandom_range(1) ? '1 : '0;
                    t.touch_y = $urandom_range(1) ? '1 : '0;
                end else begin
                    t.touch_x = w.cx;
                    t.touch_y = w.cy;
                end
                send_touch(t, 1'b0, 1'b0, '0);
                // now and then hold off until the block has caught up
                if ($urandom_range(149) == 0)
                    quiesce(0);
            end
        end

        quiesce(SETTLE);
        $display("covered %0d touch words (%0d directed), %0d reports checked",
                 words_taken, DIRECTED_ROWS, reports_checked);
        $display("%0d window setup writes over %0d random phases and four idle mixes",
                 setup_writes, PHASES);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
